// File: rtl/bitmap_font_quad_layout_defines.svh
// Assertion macros used by the text layout top level
`ifndef BITMAP_FONT_QUAD_LAYOUT_DEFINES_SVH
`define BITMAP_FONT_QUAD_LAYOUT_DEFINES_SVH

// Check a same-cycle implication on the main clock, off during reset
`define BFQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a next-cycle implication on the main clock, off during reset
`define BFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bfq_pkg.sv
// Package: widths, codes, types and helpers of the text layout block
`timescale 1ns / 1ps
package bfq_pkg;

    // Glyph atlas geometry
    localparam int NUM_GLYPHS   = 256;
    localparam int GRID_COLUMNS = 16;
    localparam int GLYPH_AW     = $clog2(NUM_GLYPHS);

    // Field widths
    localparam int CODE_W  = 8;
    localparam int WVAL_W  = 7;
    localparam int CELL_W  = 7;
    localparam int SCALE_W = 12;
    localparam int ORG_W   = 24;
    localparam int COLOR_W = 32;
    localparam int POS_W   = 32;
    localparam int PEN_W   = 31;
    localparam int ADV_W   = CELL_W + SCALE_W;
    localparam int TEX_W   = 11;
    localparam int TEXR_W  = 16;
    localparam int WIDE_W  = POS_W + 2;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int RIDX_W  = 3;
    localparam int VCNT_W  = 3;

    // Constants
    localparam logic [WVAL_W-1:0]  DEFAULT_WIDTH = WVAL_W'(6);
    localparam logic [CODE_W-1:0]  SPACE_CODE    = CODE_W'(32);
    localparam logic [TEX_W-1:0]   TEX_MAX       = '1;
    localparam logic [PEN_W-1:0]   PEN_MAX       = '1;
    localparam logic [VCNT_W-1:0]  LAST_VERT     = VCNT_W'(5);

    // Request types
    localparam logic REQ_WIDTH = 1'b0;
    localparam logic REQ_CHAR  = 1'b1;

    // Register indexes
    localparam logic [RIDX_W-1:0] REG_CELL_WIDTH  = RIDX_W'(0);
    localparam logic [RIDX_W-1:0] REG_CELL_HEIGHT = RIDX_W'(1);
    localparam logic [RIDX_W-1:0] REG_SCALE       = RIDX_W'(2);
    localparam logic [RIDX_W-1:0] REG_ORIGIN_X    = RIDX_W'(3);
    localparam logic [RIDX_W-1:0] REG_ORIGIN_Y    = RIDX_W'(4);
    localparam logic [RIDX_W-1:0] REG_TEXT_COLOR  = RIDX_W'(5);

    // Register reset values
    localparam logic [CELL_W-1:0]   RST_CELL_WIDTH  = CELL_W'(16);
    localparam logic [CELL_W-1:0]   RST_CELL_HEIGHT = CELL_W'(16);
    localparam logic [SCALE_W-1:0]  RST_SCALE       = SCALE_W'(256);
    localparam logic [COLOR_W-1:0]  RST_TEXT_COLOR  = '1;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [CELL_W-1:0]        cell_width;
        logic [CELL_W-1:0]        cell_height;
        logic [SCALE_W-1:0]       scale;
        logic signed [ORG_W-1:0]  origin_x;
        logic signed [ORG_W-1:0]  origin_y;
        logic [COLOR_W-1:0]       text_color;
        logic [ADV_W-1:0]         cw_scaled;
        logic [ADV_W-1:0]         ch_scaled;
    } t_cfg;

    // Character after the width lookup, ready for pen update
    typedef struct packed {
        logic               valid;
        logic               is_space;
        logic               first;
        logic               eos;
        logic [ADV_W-1:0]   adv;
        logic [TEX_W-1:0]   u0;
        logic [TEX_W-1:0]   u1;
        logic [TEX_W-1:0]   v0;
        logic [TEX_W-1:0]   v1;
    } t_glyph_item;

    // Clamp a wide signed position to 32 bits
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic signed [POS_W-1:0] res;
        if (!v[WIDE_W-1] && (v[WIDE_W-2:POS_W-1] != '0)) begin
            res = {1'b0, {(POS_W-1){1'b1}}};
        end else if (v[WIDE_W-1] && (v[WIDE_W-2:POS_W-1] != '1)) begin
            res = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

    // Clamp a texel coordinate to 11 bits
    function automatic logic [TEX_W-1:0] sat_tex(input logic [TEXR_W-1:0] v);
        logic [TEX_W-1:0] res;
        if (v > TEXR_W'(TEX_MAX)) begin
            res = TEX_MAX;
        end else begin
            res = v[TEX_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/bfq_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module bfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bfq_cfg.sv
// APB register file holding the layout configuration
`timescale 1ns / 1ps
module bfq_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bfq_pkg::PADDR_W-1:0] paddr,
    input  logic [bfq_pkg::PDATA_W-1:0] pwdata,
    output logic [bfq_pkg::PDATA_W-1:0] prdata,
    output logic                       pready,
    output bfq_pkg::t_cfg              o_cfg
);
    import bfq_pkg::*;

    logic [CELL_W-1:0]       r_cell_width;
    logic [CELL_W-1:0]       r_cell_height;
    logic [SCALE_W-1:0]      r_scale;
    logic signed [ORG_W-1:0] r_origin_x;
    logic signed [ORG_W-1:0] r_origin_y;
    logic [COLOR_W-1:0]      r_text_color;
    logic [ADV_W-1:0]        r_cw_scaled;
    logic [ADV_W-1:0]        r_ch_scaled;
    logic                    wr_en;
    logic [RIDX_W-1:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width  <= RST_CELL_WIDTH;
            r_cell_height <= RST_CELL_HEIGHT;
            r_scale       <= RST_SCALE;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_text_color  <= RST_TEXT_COLOR;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CELL_WIDTH:  r_cell_width  <= pwdata[CELL_W-1:0];
                REG_CELL_HEIGHT: r_cell_height <= pwdata[CELL_W-1:0];
                REG_SCALE:       r_scale       <= pwdata[SCALE_W-1:0];
                REG_ORIGIN_X:    r_origin_x    <= pwdata[ORG_W-1:0];
                REG_ORIGIN_Y:    r_origin_y    <= pwdata[ORG_W-1:0];
                REG_TEXT_COLOR:  r_text_color  <= pwdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Precompute the scaled cell size
    always_ff @(posedge i_clk) begin
        r_cw_scaled <= ADV_W'(r_cell_width) * ADV_W'(r_scale);
        r_ch_scaled <= ADV_W'(r_cell_height) * ADV_W'(r_scale);
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_CELL_WIDTH:  prdata = PDATA_W'(r_cell_width);
            REG_CELL_HEIGHT: prdata = PDATA_W'(r_cell_height);
            REG_SCALE:       prdata = PDATA_W'(r_scale);
            REG_ORIGIN_X:    prdata = PDATA_W'(r_origin_x);
            REG_ORIGIN_Y:    prdata = PDATA_W'(r_origin_y);
            REG_TEXT_COLOR:  prdata = PDATA_W'(r_text_color);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        o_cfg.cell_width  = r_cell_width;
        o_cfg.cell_height = r_cell_height;
        o_cfg.scale       = r_scale;
        o_cfg.origin_x    = r_origin_x;
        o_cfg.origin_y    = r_origin_y;
        o_cfg.text_color  = r_text_color;
        o_cfg.cw_scaled   = r_cw_scaled;
        o_cfg.ch_scaled   = r_ch_scaled;
    end

endmodule

// File: rtl/bfq_glyph.sv
// Glyph width table, width lookup and advance/texel computation
`timescale 1ns / 1ps
module bfq_glyph (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [bfq_pkg::CODE_W-1:0]  i_char_code,
    input  logic [bfq_pkg::WVAL_W-1:0]  i_width_value,
    input  logic                        i_first_of_string,
    input  logic                        i_last_of_string,
    input  bfq_pkg::t_cfg               i_cfg,
    input  logic                        i_take,
    output bfq_pkg::t_glyph_item        o_item
);
    import bfq_pkg::*;

    // Lookup stage, waiting on the table read
    logic                r_a_valid;
    logic [CODE_W-1:0]   r_a_code;
    logic                r_a_known;
    logic                r_a_in_range;
    logic                r_a_first;
    logic                r_a_eos;

    // Advance stage
    logic                r_b_valid;
    t_glyph_item         r_b_item;
    t_glyph_item         n_b_item;

    logic [NUM_GLYPHS-1:0] r_known;
    logic [WVAL_W-1:0]     ram_q;
    logic [GLYPH_AW-1:0]   addr;
    logic                  in_range;
    logic                  accept;
    logic                  wr_en;
    logic                  rd_en;
    logic                  b_free;
    logic                  a_free;
    logic                  a_move;
    logic [WVAL_W-1:0]     width_sel;
    logic [CODE_W-1:0]     col;
    logic [CODE_W-1:0]     row;
    logic [TEXR_W-1:0]     u0_raw;
    logic [TEXR_W-1:0]     v0_raw;

    assign addr     = i_char_code[GLYPH_AW-1:0];
    assign in_range = (CODE_W+1)'(i_char_code) < (CODE_W+1)'(NUM_GLYPHS);

    assign b_free     = !r_b_valid || i_take;
    assign a_free     = !r_a_valid || b_free;
    assign a_move     = r_a_valid && b_free;
    assign o_in_stall = !a_free;
    assign accept     = i_in_valid && a_free;
    assign wr_en      = accept && (i_req_type == REQ_WIDTH) && in_range;
    assign rd_en      = accept && (i_req_type == REQ_CHAR);

    bfq_ram #(
        .WIDTH (WVAL_W),
        .DEPTH (NUM_GLYPHS)
    ) u_width_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (addr),
        .i_wdata (i_width_value),
        .i_re    (rd_en),
        .i_raddr (addr),
        .o_rdata (ram_q)
    );

    // Track entries written since reset; others read as the default width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= '0;
        end else if (wr_en) begin
            r_known[addr] <= 1'b1;
        end
    end

    // Lookup stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (rd_en) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    // Lookup stage payload
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_a_code     <= i_char_code;
            r_a_known    <= r_known[addr];
            r_a_in_range <= in_range;
            r_a_first    <= i_first_of_string;
            r_a_eos      <= i_last_of_string;
        end
    end

    // Select width, scale it and place the glyph cell in the atlas
    always_comb begin
        if (!r_a_in_range) begin
            width_sel = '0;
        end else if (r_a_known) begin
            width_sel = ram_q;
        end else begin
            width_sel = DEFAULT_WIDTH;
        end
        col    = CODE_W'(r_a_code % GRID_COLUMNS);
        row    = CODE_W'(r_a_code / GRID_COLUMNS);
        u0_raw = TEXR_W'(col) * TEXR_W'(i_cfg.cell_width);
        v0_raw = TEXR_W'(row) * TEXR_W'(i_cfg.cell_height);

        n_b_item.valid    = 1'b1;
        n_b_item.is_space = (r_a_code == SPACE_CODE);
        n_b_item.first    = r_a_first;
        n_b_item.eos      = r_a_eos;
        n_b_item.adv      = ADV_W'(width_sel) * ADV_W'(i_cfg.scale);
        n_b_item.u0       = sat_tex(u0_raw);
        n_b_item.v0       = sat_tex(v0_raw);
        n_b_item.u1       = sat_tex(u0_raw + TEXR_W'(i_cfg.cell_width));
        n_b_item.v1       = sat_tex(v0_raw + TEXR_W'(i_cfg.cell_height));
    end

    // Advance stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
        end else if (i_take) begin
            r_b_valid <= 1'b0;
        end
    end

    // Advance stage payload
    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_item <= n_b_item;
        end
    end

    always_comb begin
        o_item       = r_b_item;
        o_item.valid = r_b_valid;
    end

endmodule

// File: rtl/bfq_emit.sv
// Pen update, quad geometry and per-vertex result sequencing
`timescale 1ns / 1ps
module bfq_emit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bfq_pkg::t_cfg                      i_cfg,
    input  bfq_pkg::t_glyph_item               i_item,
    output logic                               o_take,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_is_vertex,
    output logic [bfq_pkg::TEX_W-1:0]          o_tex_u,
    output logic [bfq_pkg::TEX_W-1:0]          o_tex_v,
    output logic [bfq_pkg::COLOR_W-1:0]        o_color,
    output logic signed [bfq_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [bfq_pkg::POS_W-1:0]   o_pos_y,
    output logic [bfq_pkg::PEN_W-1:0]          o_string_advance,
    output logic                               o_last_of_item,
    output logic                               o_end_of_string
);
    import bfq_pkg::*;

    // Pen state
    logic [PEN_W-1:0] r_pen;

    // Quad holding register
    logic                    r_q_valid;
    logic [VCNT_W-1:0]       r_q_cnt;
    logic                    r_q_is_space;
    logic                    r_q_eos;
    logic signed [POS_W-1:0] r_q_x0;
    logic signed [POS_W-1:0] r_q_x1;
    logic signed [POS_W-1:0] r_q_y0;
    logic signed [POS_W-1:0] r_q_y1;
    logic [TEX_W-1:0]        r_q_u0;
    logic [TEX_W-1:0]        r_q_u1;
    logic [TEX_W-1:0]        r_q_v0;
    logic [TEX_W-1:0]        r_q_v1;
    logic [PEN_W-1:0]        r_q_adv;

    // Output register
    logic                    r_out_valid;
    logic                    r_o_is_vertex;
    logic [TEX_W-1:0]        r_o_tex_u;
    logic [TEX_W-1:0]        r_o_tex_v;
    logic [COLOR_W-1:0]      r_o_color;
    logic signed [POS_W-1:0] r_o_pos_x;
    logic signed [POS_W-1:0] r_o_pos_y;
    logic [PEN_W-1:0]        r_o_adv;
    logic                    r_o_last;
    logic                    r_o_eos;

    logic                     out_free;
    logic                     q_emit;
    logic                     q_last;
    logic                     q_free;
    logic                     hi_x;
    logic                     hi_y;
    logic [PEN_W-1:0]         pen_base;
    logic [PEN_W:0]           pen_sum;
    logic [PEN_W-1:0]         n_pen;
    logic signed [WIDE_W-1:0] x0_wide;
    logic signed [WIDE_W-1:0] x1_wide;
    logic signed [WIDE_W-1:0] y0_wide;
    logic signed [WIDE_W-1:0] y1_wide;

    assign out_free = !r_out_valid || !i_out_stall;
    assign q_emit   = r_q_valid && out_free;
    assign q_last   = r_q_is_space || (r_q_cnt == LAST_VERT);
    assign q_free   = !r_q_valid || (q_emit && q_last);
    assign o_take   = i_item.valid && q_free;

    // Move the pen and build the quad corners
    always_comb begin
        pen_base = i_item.first ? '0 : r_pen;
        pen_sum  = (PEN_W+1)'(pen_base) + (PEN_W+1)'(i_item.adv);
        n_pen    = pen_sum[PEN_W] ? PEN_MAX : pen_sum[PEN_W-1:0];
        x0_wide  = WIDE_W'(i_cfg.origin_x) + $signed(WIDE_W'(pen_base));
        x1_wide  = x0_wide + $signed(WIDE_W'(i_cfg.cw_scaled));
        y0_wide  = WIDE_W'(i_cfg.origin_y);
        y1_wide  = y0_wide + $signed(WIDE_W'(i_cfg.ch_scaled));
    end

    // Hold the pen offset across characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen <= '0;
        end else if (o_take) begin
            r_pen <= n_pen;
        end
    end

    // Quad register valid and vertex counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_q_cnt   <= '0;
        end else if (o_take) begin
            r_q_valid <= 1'b1;
            r_q_cnt   <= '0;
        end else if (q_emit) begin
            if (q_last) begin
                r_q_valid <= 1'b0;
            end
            r_q_cnt <= r_q_cnt + VCNT_W'(1);
        end
    end

    // Quad register payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_q_is_space <= i_item.is_space;
            r_q_eos      <= i_item.eos;
            r_q_x0       <= sat_pos(x0_wide);
            r_q_x1       <= sat_pos(x1_wide);
            r_q_y0       <= sat_pos(y0_wide);
            r_q_y1       <= sat_pos(y1_wide);
            r_q_u0       <= i_item.u0;
            r_q_u1       <= i_item.u1;
            r_q_v0       <= i_item.v0;
            r_q_v1       <= i_item.v1;
            r_q_adv      <= n_pen;
        end
    end

    // Corner select in triangle order
    always_comb begin
        case (r_q_cnt)
            VCNT_W'(0): begin hi_x = 1'b0; hi_y = 1'b0; end
            VCNT_W'(1): begin hi_x = 1'b0; hi_y = 1'b1; end
            VCNT_W'(2): begin hi_x = 1'b1; hi_y = 1'b0; end
            VCNT_W'(3): begin hi_x = 1'b1; hi_y = 1'b0; end
            VCNT_W'(4): begin hi_x = 1'b0; hi_y = 1'b1; end
            VCNT_W'(5): begin hi_x = 1'b1; hi_y = 1'b1; end
            default:    begin hi_x = 1'b0; hi_y = 1'b0; end
        endcase
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (q_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (q_emit) begin
            r_o_adv  <= r_q_adv;
            r_o_last <= q_last;
            r_o_eos  <= r_q_eos;
            if (r_q_is_space) begin
                r_o_is_vertex <= 1'b0;
                r_o_tex_u     <= '0;
                r_o_tex_v     <= '0;
                r_o_color     <= '0;
                r_o_pos_x     <= r_q_x0;
                r_o_pos_y     <= r_q_y0;
            end else begin
                r_o_is_vertex <= 1'b1;
                r_o_tex_u     <= hi_x ? r_q_u1 : r_q_u0;
                r_o_tex_v     <= hi_y ? r_q_v1 : r_q_v0;
                r_o_color     <= i_cfg.text_color;
                r_o_pos_x     <= hi_x ? r_q_x1 : r_q_x0;
                r_o_pos_y     <= hi_y ? r_q_y1 : r_q_y0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_is_vertex      = r_o_is_vertex;
    assign o_tex_u          = r_o_tex_u;
    assign o_tex_v          = r_o_tex_v;
    assign o_color          = r_o_color;
    assign o_pos_x          = r_o_pos_x;
    assign o_pos_y          = r_o_pos_y;
    assign o_string_advance = r_o_adv;
    assign o_last_of_item   = r_o_last;
    assign o_end_of_string  = r_o_eos;

endmodule

// File: rtl/bitmap_font_quad_layout.sv
// Top level: text layout of character codes into textured quad vertices
//
//  Channel  Direction  Handshake                    Payload
//  input    in         i_in_valid / o_in_stall      req_type, char_code, width_value,
//                                                   first_of_string, last_of_string
//  output   out        o_out_valid / i_out_stall    is_vertex .. end_of_string
//  config   in         psel/penable/pwrite/pready   paddr, pwdata, prdata
//
//  A character yields six vertices, one per cycle from the output sequencer while
//  the output is not stalled; a space yields one result, and a width write writes
//  the width RAM at acceptance and yields nothing. New characters are accepted into
//  the lookup and advance stages while a quad is still being emitted. The path from
//  acceptance to the first result runs through RAM read, advance multiply, pen update
//  and output register. Reset is synchronous, active low; all widths read as 6 right
//  after reset. Output stall backs up through the quad register and the advance and lookup stages to the input stall.
`timescale 1ns / 1ps
`include "bitmap_font_quad_layout_defines.svh"
module bitmap_font_quad_layout (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bfq_pkg::PADDR_W-1:0]        paddr,
    input  logic [bfq_pkg::PDATA_W-1:0]        pwdata,
    output logic [bfq_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    // Input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic [bfq_pkg::CODE_W-1:0]         i_char_code,
    input  logic [bfq_pkg::WVAL_W-1:0]         i_width_value,
    input  logic                               i_first_of_string,
    input  logic                               i_last_of_string,
    // Output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_is_vertex,
    output logic [bfq_pkg::TEX_W-1:0]          o_tex_u,
    output logic [bfq_pkg::TEX_W-1:0]          o_tex_v,
    output logic [bfq_pkg::COLOR_W-1:0]        o_color,
    output logic signed [bfq_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [bfq_pkg::POS_W-1:0]   o_pos_y,
    output logic [bfq_pkg::PEN_W-1:0]          o_string_advance,
    output logic                               o_last_of_item,
    output logic                               o_end_of_string
);
    import bfq_pkg::*;

    t_cfg        cfg;
    t_glyph_item item;
    logic        take;
    logic        out_xfer;

    bfq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bfq_glyph u_glyph (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_char_code       (i_char_code),
        .i_width_value     (i_width_value),
        .i_first_of_string (i_first_of_string),
        .i_last_of_string  (i_last_of_string),
        .i_cfg             (cfg),
        .i_take            (take),
        .o_item            (item)
    );

    bfq_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_item           (item),
        .o_take           (take),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_vertex      (o_is_vertex),
        .o_tex_u          (o_tex_u),
        .o_tex_v          (o_tex_v),
        .o_color          (o_color),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_string_advance (o_string_advance),
        .o_last_of_item   (o_last_of_item),
        .o_end_of_string  (o_end_of_string)
    );

    assign out_xfer = o_out_valid && !i_out_stall;

    // A space result is always the only and last result of its character
    `BFQ_ASSERT_NOW(a_space_single, o_out_valid && !o_is_vertex, o_last_of_item && (o_color == '0) && (o_tex_u == '0) && (o_tex_v == '0), "space result malformed")
    // Vertices of one quad follow each other with no gap
    `BFQ_ASSERT_NEXT(a_quad_no_gap, out_xfer && !o_last_of_item, o_out_valid, "gap inside a quad")
    // All vertices of one quad carry the same pen offset
    `BFQ_ASSERT_NEXT(a_quad_same_pen, out_xfer && !o_last_of_item, o_string_advance == $past(o_string_advance), "pen changed inside a quad")
    // End of string marker is constant across one quad
    `BFQ_ASSERT_NEXT(a_quad_same_eos, out_xfer && !o_last_of_item, o_end_of_string == $past(o_end_of_string), "end of string changed inside a quad")

endmodule

// File: verif/bitmap_font_quad_layout_tb.sv
// Testbench for the text layout block: directed and random strings checked against a predictor
`timescale 1ns / 1ps
module bitmap_font_quad_layout_tb;
    import bfq_pkg::*;

    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam int   MAX_GAP       = 16;
    localparam int   SETTLE_CYCLES = 10;
    localparam int   PEN_RUN       = 8;

    // One vertex (or space advance) as it leaves the block
    typedef struct packed {
        logic                    is_vertex;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
        logic [COLOR_W-1:0]      color;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [PEN_W-1:0]        advance;
        logic                    last_of_item;
        logic                    end_of_string;
    } t_vertex;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_req_type;
    logic [CODE_W-1:0]       i_char_code;
    logic [WVAL_W-1:0]       i_width_value;
    logic                    i_first_of_string;
    logic                    i_last_of_string;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_is_vertex;
    logic [TEX_W-1:0]        o_tex_u;
    logic [TEX_W-1:0]        o_tex_v;
    logic [COLOR_W-1:0]      o_color;
    logic signed [POS_W-1:0] o_pos_x;
    logic signed [POS_W-1:0] o_pos_y;
    logic [PEN_W-1:0]        o_string_advance;
    logic                    o_last_of_item;
    logic                    o_end_of_string;

    // Predicted vertices, oldest first
    t_vertex pending_vertices[$];

    // Shadow of the layout state and registers
    logic [WVAL_W-1:0]       glyph_widths [NUM_GLYPHS];
    longint                  pen_pos;
    logic [CELL_W-1:0]       cell_w;
    logic [CELL_W-1:0]       cell_h;
    logic [SCALE_W-1:0]      scale_q;
    logic signed [ORG_W-1:0] org_x;
    logic signed [ORG_W-1:0] org_y;
    logic [COLOR_W-1:0]      text_rgb;

    int     errors;
    int     n_width;
    int     n_chars;
    int     n_spaces;
    int     n_results;
    int     rx_hold;
    bit     no_gaps;
    longint cycle_count;

    bitmap_font_quad_layout dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_char_code      (i_char_code),
        .i_width_value    (i_width_value),
        .i_first_of_string(i_first_of_string),
        .i_last_of_string (i_last_of_string),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_vertex      (o_is_vertex),
        .o_tex_u          (o_tex_u),
        .o_tex_v          (o_tex_v),
        .o_color          (o_color),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_string_advance (o_string_advance),
        .o_last_of_item   (o_last_of_item),
        .o_end_of_string  (o_end_of_string)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Clamp a wide position to the signed 32-bit range
    function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return POS_W'(v);
    endfunction

    function automatic logic [TEX_W-1:0] clamp_tex(longint v);
        if (v > longint'(TEX_MAX)) begin
            return TEX_MAX;
        end
        return TEX_W'(v);
    endfunction

    function automatic void push_vertex(logic isv, logic [TEX_W-1:0] u, logic [TEX_W-1:0] v,
                                        logic [COLOR_W-1:0] col, longint px, longint py,
                                        logic lst, logic eos);
        t_vertex e;
        e.is_vertex     = isv;
        e.tex_u         = u;
        e.tex_v         = v;
        e.color         = col;
        e.pos_x         = clamp_pos(px);
        e.pos_y         = clamp_pos(py);
        e.advance       = PEN_W'(pen_pos);
        e.last_of_item  = lst;
        e.end_of_string = eos;
        pending_vertices.push_back(e);
    endfunction

    // Update the shadow state for one accepted transaction and queue its vertices
    function automatic void lay_out_glyph(logic req, logic [CODE_W-1:0] code,
                                          logic [WVAL_W-1:0] wval, logic first, logic last);
        longint            adv;
        longint            x0;
        longint            x1;
        longint            y0;
        longint            y1;
        logic [TEX_W-1:0]  u0;
        logic [TEX_W-1:0]  u1;
        logic [TEX_W-1:0]  v0;
        logic [TEX_W-1:0]  v1;
        longint            u_raw;
        longint            v_raw;
        logic [WVAL_W-1:0] w;
        if (req == REQ_WIDTH) begin
            if (int'(code) < NUM_GLYPHS) begin
                glyph_widths[code] = wval;
            end
            n_width++;
            return;
        end
        if (first) begin
            pen_pos = 0;
        end
        w  = (int'(code) < NUM_GLYPHS) ? glyph_widths[code] : '0;
        adv = longint'(w) * longint'(scale_q);
        x0  = longint'(org_x) + pen_pos;
        y0  = longint'(org_y);
        // Advance the pen and hold it at its ceiling
        pen_pos = pen_pos + adv;
        if (pen_pos > longint'(PEN_MAX)) begin
            pen_pos = longint'(PEN_MAX);
        end
        if (code == SPACE_CODE) begin
            push_vertex(1'b0, '0, '0, '0, x0, y0, 1'b1, last);
            n_spaces++;
            return;
        end
        x1    = x0 + longint'(cell_w) * longint'(scale_q);
        y1    = y0 + longint'(cell_h) * longint'(scale_q);
        u_raw = (longint'(code) % GRID_COLUMNS) * longint'(cell_w);
        v_raw = (longint'(code) / GRID_COLUMNS) * longint'(cell_h);
        u0    = clamp_tex(u_raw);
        v0    = clamp_tex(v_raw);
        u1    = clamp_tex(u_raw + longint'(cell_w));
        v1    = clamp_tex(v_raw + longint'(cell_h));
        // Two triangles: top-left, bottom-left, top-right, then top-right, bottom-left, bottom-right
        push_vertex(1'b1, u0, v0, text_rgb, x0, y0, 1'b0, last);
        push_vertex(1'b1, u0, v1, text_rgb, x0, y1, 1'b0, last);
        push_vertex(1'b1, u1, v0, text_rgb, x1, y0, 1'b0, last);
        push_vertex(1'b1, u1, v0, text_rgb, x1, y0, 1'b0, last);
        push_vertex(1'b1, u0, v1, text_rgb, x0, y1, 1'b0, last);
        push_vertex(1'b1, u1, v1, text_rgb, x1, y1, 1'b1, last);
        n_chars++;
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // Compare one output transaction with the oldest prediction
    function automatic void check_vertex();
        t_vertex want;
        n_results++;
        if (pending_vertices.size() == 0) begin
            errors++;
            $display("%0t: output transaction with nothing predicted, pos_x 0x%0h",
                     $time, o_pos_x);
            return;
        end
        want = pending_vertices.pop_front();
        compare_field("is_vertex", want.is_vertex, o_is_vertex);
        compare_field("tex_u", want.tex_u, o_tex_u);
        compare_field("tex_v", want.tex_v, o_tex_v);
        compare_field("color", want.color, o_color);
        compare_field("pos_x", want.pos_x, o_pos_x);
        compare_field("pos_y", want.pos_y, o_pos_y);
        compare_field("string_advance", want.advance, o_string_advance);
        compare_field("last_of_item", want.last_of_item, o_last_of_item);
        compare_field("end_of_string", want.end_of_string, o_end_of_string);
    endfunction

    // Receive results and draw a stall run after each one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_vertex();
            rx_hold = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (rx_hold > 0) begin
            i_out_stall <= 1'b1;
            rx_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL bitmap_font_quad_layout");
            $finish;
        end
    end

    // Present one transaction after a random gap and wait for it to be taken
    task automatic send_item(logic req, logic [CODE_W-1:0] code, logic [WVAL_W-1:0] wval,
                             logic first, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_type        <= req;
        i_char_code       <= code;
        i_width_value     <= wval;
        i_first_of_string <= first;
        i_last_of_string  <= last;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        lay_out_glyph(req, code, wval, first, last);
    endtask

    // Drop valid and wait until every predicted vertex has come out
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register through the setup and access phases
    task automatic write_register(logic [RIDX_W-1:0] idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_CELL_WIDTH:  cell_w   = value[CELL_W-1:0];
            REG_CELL_HEIGHT: cell_h   = value[CELL_W-1:0];
            REG_SCALE:       scale_q  = value[SCALE_W-1:0];
            REG_ORIGIN_X:    org_x    = value[ORG_W-1:0];
            REG_ORIGIN_Y:    org_y    = value[ORG_W-1:0];
            REG_TEXT_COLOR:  text_rgb = value;
            default: ;
        endcase
    endtask

    task automatic write_all_registers(logic [CELL_W-1:0] cw, logic [CELL_W-1:0] ch,
                                       logic [SCALE_W-1:0] sc, logic [PDATA_W-1:0] ox,
                                       logic [PDATA_W-1:0] oy, logic [COLOR_W-1:0] col);
        write_register(REG_CELL_WIDTH, PDATA_W'(cw));
        write_register(REG_CELL_HEIGHT, PDATA_W'(ch));
        write_register(REG_SCALE, PDATA_W'(sc));
        write_register(REG_ORIGIN_X, ox);
        write_register(REG_ORIGIN_Y, oy);
        write_register(REG_TEXT_COLOR, col);
    endtask

    // Default widths and registers straight out of reset
    task automatic test_reset_defaults();
        send_item(REQ_CHAR, 8'h41, '0, 1'b1, 1'b0);
        send_item(REQ_CHAR, SPACE_CODE, '0, 1'b0, 1'b0);
        send_item(REQ_CHAR, 8'h7E, '0, 1'b0, 1'b1);
        // A width write ignores the string flags
        send_item(REQ_WIDTH, 8'h00, 7'd0, 1'b1, 1'b1);
        send_item(REQ_WIDTH, 8'hFF, 7'h7F, 1'b1, 1'b0);
        send_item(REQ_WIDTH, SPACE_CODE, 7'd65, 1'b0, 1'b1);
        send_item(REQ_CHAR, 8'h00, '0, 1'b1, 1'b0);
        send_item(REQ_CHAR, 8'hFF, '0, 1'b0, 1'b0);
        send_item(REQ_CHAR, SPACE_CODE, '0, 1'b0, 1'b0);
        send_item(REQ_CHAR, 8'h0F, '0, 1'b0, 1'b1);
    endtask

    // Zero and full-scale cells and scale at the origin extremes, then 64x1 cells at unit scale
    task automatic test_extreme_registers();
        wait_for_results();
        write_all_registers(7'd0, 7'd0, 12'd0, 32'h0080_0000, 32'h007F_FFFF, 32'h0000_0000);
        send_item(REQ_CHAR, 8'hFF, '0, 1'b1, 1'b1);
        send_item(REQ_CHAR, SPACE_CODE, '0, 1'b1, 1'b1);
        send_item(REQ_CHAR, 8'h5A, '0, 1'b0, 1'b0);
        wait_for_results();
        write_all_registers(7'h7F, 7'h7F, 12'hFFF, 32'h007F_FFFF, 32'hFF80_0000, 32'hA5A5_5A5A);
        send_item(REQ_CHAR, 8'hFF, '0, 1'b1, 1'b0);
        send_item(REQ_CHAR, 8'h11, '0, 1'b0, 1'b0);
        send_item(REQ_CHAR, SPACE_CODE, '0, 1'b0, 1'b0);
        send_item(REQ_CHAR, 8'hF0, '0, 1'b0, 1'b1);
        wait_for_results();
        write_all_registers(7'd64, 7'd1, 12'd1, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(REQ_CHAR, 8'h80, '0, 1'b1, 1'b1);
    endtask

    // Run back-to-back full-width spaces at full scale, then restart a string at the origin
    task automatic test_wide_spaces();
        int k;
        wait_for_results();
        write_all_registers(7'h7F, 7'h7F, 12'hFFF, 32'h007F_FFFF, 32'h0000_1000, 32'h1234_5678);
        no_gaps = 1'b1;
        send_item(REQ_WIDTH, SPACE_CODE, 7'h7F, 1'b0, 1'b0);
        send_item(REQ_CHAR, SPACE_CODE, '0, 1'b1, 1'b0);
        for (k = 0; k < PEN_RUN; k++) begin
            send_item(REQ_CHAR, SPACE_CODE, '0, 1'b0, 1'b0);
        end
        send_item(REQ_CHAR, 8'h57, '0, 1'b0, 1'b1);
        // The next string starts over at the origin
        send_item(REQ_CHAR, 8'h57, '0, 1'b1, 1'b1);
        no_gaps = 1'b0;
    endtask

    // Random strings over several register settings, with width writes and noise mixed in
    task automatic test_random_strings();
        int               phase;
        int               sent;
        int               len;
        int               k;
        int               pick;
        bit               paused;
        logic [CODE_W-1:0] code;
        paused = 1'b0;
        for (phase = 0; phase < 4; phase++) begin
            wait_for_results();
            case (phase)
                0: write_all_registers(7'd1, 7'd1, SCALE_W'($urandom_range(0, 255)),
                                       $urandom, $urandom, $urandom);
                1: write_all_registers(7'd64, 7'd64, 12'hFFF, $urandom, $urandom, $urandom);
                default: write_all_registers(CELL_W'($urandom_range(0, 127)),
                                             CELL_W'($urandom_range(0, 127)),
                                             SCALE_W'($urandom_range(0, 4095)),
                                             $urandom, $urandom, $urandom);
            endcase
            no_gaps = (phase == 2);
            sent = 0;
            while (sent < 24) begin
                // Hold the sender once until the block has emptied
                if (phase == 1 && sent >= 16 && !paused) begin
                    wait_for_results();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    code = $urandom_range(0, 1) ? CODE_W'($urandom_range(32, 127))
                                                : CODE_W'($urandom_range(0, 255));
                    send_item(REQ_WIDTH, code, WVAL_W'($urandom_range(0, 127)),
                              1'($urandom), 1'($urandom));
                    sent++;
                end else if (pick == 2) begin
                    send_item(REQ_CHAR, CODE_W'($urandom_range(0, 255)),
                              WVAL_W'($urandom_range(0, 127)), 1'($urandom), 1'($urandom));
                    sent++;
                end else begin
                    len = $urandom_range(1, 6);
                    for (k = 0; k < len; k++) begin
                        code = ($urandom_range(0, 4) == 0) ? SPACE_CODE
                                                           : CODE_W'($urandom_range(0, 255));
                        send_item(REQ_CHAR, code, WVAL_W'($urandom_range(0, 127)),
                                  k == 0, k == len - 1);
                        sent++;
                    end
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        // Drive every input and clear the shadow state
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        i_in_valid        <= 1'b0;
        i_req_type        <= REQ_CHAR;
        i_char_code       <= '0;
        i_width_value     <= '0;
        i_first_of_string <= 1'b0;
        i_last_of_string  <= 1'b0;
        i_out_stall       <= 1'b0;
        foreach (glyph_widths[i]) glyph_widths[i] = DEFAULT_WIDTH;
        pen_pos     = 0;
        cell_w      = RST_CELL_WIDTH;
        cell_h      = RST_CELL_HEIGHT;
        scale_q     = RST_SCALE;
        org_x       = '0;
        org_y       = '0;
        text_rgb    = RST_TEXT_COLOR;
        errors      = 0;
        n_width     = 0;
        n_chars     = 0;
        n_spaces    = 0;
        n_results   = 0;
        rx_hold     = 0;
        no_gaps     = 1'b0;
        cycle_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_defaults();
        test_extreme_registers();
        test_wide_spaces();
        test_random_strings();
        wait_for_results();

        $display("Sent %0d width writes, %0d glyphs and %0d spaces; checked %0d results",
                 n_width, n_chars, n_spaces, n_results);
        $display("Settings ranged over zero and full-scale cells and scale, origin extremes, "
                 , "and a back-to-back run of full-width spaces");
        if (errors == 0 && pending_vertices.size() == 0) begin
            $display("PASS bitmap_font_quad_layout");
        end else begin
            $display("FAIL bitmap_font_quad_layout");
        end
        $finish;
    end

endmodule
